// File: src/lfu_pkg.sv
// Shared widths, reset values and update codes for the LFU cache.
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int KeyW   = 32;
  localparam int ValW   = 32;
  localparam int CountW = 16;
  localparam int CfgW   = 5;

  localparam int EntriesDef = 16;

  localparam logic [CfgW-1:0] LimitRst = CfgW'(16);

  typedef enum logic [1:0] {
    UPD_NONE    = 2'd0,
    UPD_HIT     = 2'd1,
    UPD_REPLACE = 2'd2,
    UPD_INSERT  = 2'd3
  } upd_kind_e;

endpackage

// File: src/lfu_cell.sv
// One cache slot: holds an entry, joins the lookup wave and applies the broadcast update.
`timescale 1ns / 1ps
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int RankW = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [1+KeyW+1+ValW+RankW+1+CountW+RankW+1-1:0] wave_i,
  output logic [1+KeyW+1+ValW+RankW+1+CountW+RankW+1-1:0] wave_o,
  input  logic [2+1+RankW+KeyW+ValW-1:0]                  upd_i
);

  typedef struct packed {
    logic              act;
    logic [KeyW-1:0]   key;
    logic              hit;
    logic [ValW-1:0]   hval;
    logic [RankW-1:0]  hrank;
    logic              vfound;
    logic [CountW-1:0] vcount;
    logic [RankW-1:0]  vrank;
    logic              taken;
  } wave_t;

  typedef struct packed {
    upd_kind_e        kind;
    logic             wr;
    logic [RankW-1:0] sel;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  val;
  } upd_t;

  wave_t wave_in, wave_d, wave_q;
  upd_t  upd;

  logic              valid_q, valid_d;
  logic              claim_q, claim_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [RankW-1:0]  rank_q, rank_d;
  logic              sel_me, older;

  assign wave_in = wave_t'(wave_i);
  assign upd     = upd_t'(upd_i);
  assign wave_o  = wave_q;

  always_comb begin
    wave_d  = wave_in;
    claim_d = claim_q;
    if (wave_in.act) begin
      claim_d = !valid_q && !wave_in.taken;
      if (valid_q) begin
        if (key_q == wave_in.key) begin
          wave_d.hit   = 1'b1;
          wave_d.hval  = val_q;
          wave_d.hrank = rank_q;
        end
        if (!wave_in.vfound || (cnt_q < wave_in.vcount) ||
            ((cnt_q == wave_in.vcount) && (rank_q > wave_in.vrank))) begin
          wave_d.vfound = 1'b1;
          wave_d.vcount = cnt_q;
          wave_d.vrank  = rank_q;
        end
      end else begin
        wave_d.taken = 1'b1;
      end
    end
  end

  assign sel_me = valid_q && (rank_q == upd.sel);
  assign older  = valid_q && (rank_q < upd.sel);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    unique case (upd.kind)
      UPD_HIT: begin
        if (sel_me) begin
          cnt_d  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
          rank_d = '0;
          if (upd.wr) begin
            val_d = upd.val;
          end
        end else if (older) begin
          rank_d = rank_q + 1'b1;
        end
      end
      UPD_REPLACE: begin
        if (sel_me) begin
          key_d  = upd.key;
          val_d  = upd.val;
          cnt_d  = CountW'(1);
          rank_d = '0;
        end else if (older) begin
          rank_d = rank_q + 1'b1;
        end
      end
      UPD_INSERT: begin
        if (claim_q) begin
          valid_d = 1'b1;
          key_d   = upd.key;
          val_d   = upd.val;
          cnt_d   = CountW'(1);
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      claim_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      valid_q <= valid_d;
      claim_q <= claim_d;
      wave_q  <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    rank_q <= rank_d;
  end

endmodule

// File: src/lfu_cache_lookup_insert.sv
// Top level of the LFU key/value cache: chain of slot cells, sequencer and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | mode_i, lookup_key_i, store_value_i
//   out     | output    | out_valid_o/out_ready_i| hit_o, read_value_o, evicted_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (cache_limit)
//
// For each item the lookup wave walks the cell chain one cell per cycle; the sequencer then
// latches the summary from the end of the chain and applies it once the output is free.
// Reset empties the cache at once and sets the limit to 16; no clearing pass.
// A stalled output holds the finished item in the apply step until it is taken.
`timescale 1ns / 1ps
module lfu_cache_lookup_insert
  import lfu_pkg::*;
#(
  parameter int ENTRIES = EntriesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [KeyW-1:0]        lookup_key_i,
  input  logic signed [ValW-1:0] store_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic signed [ValW-1:0] read_value_o,
  output logic                   evicted_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_data_i
);

  localparam int RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OccW  = $clog2(ENTRIES + 1);
  localparam int CmpW  = (OccW > CfgW) ? OccW : CfgW;
  localparam int WaveW = 1 + KeyW + 1 + ValW + RankW + 1 + CountW + RankW + 1;
  localparam int UpdW  = 2 + 1 + RankW + KeyW + ValW;

  typedef struct packed {
    logic              act;
    logic [KeyW-1:0]   key;
    logic              hit;
    logic [ValW-1:0]   hval;
    logic [RankW-1:0]  hrank;
    logic              vfound;
    logic [CountW-1:0] vcount;
    logic [RankW-1:0]  vrank;
    logic              taken;
  } wave_t;

  typedef struct packed {
    upd_kind_e        kind;
    logic             wr;
    logic [RankW-1:0] sel;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  val;
  } upd_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;

  wave_t           inject, sum_q, sum_d;
  logic [WaveW-1:0] chain [ENTRIES+1];
  logic [ENTRIES:0] act_vec;
  upd_t            upd;

  logic [CfgW-1:0] limit_q;
  logic [OccW-1:0] occ_q, occ_d;
  logic            mode_q;
  logic [ValW-1:0] val_q;
  logic            out_valid_q;
  logic            hit_q;
  logic [ValW-1:0] rdval_q;
  logic            ev_q, ev_d;

  logic            accept, apply, lim_nz, full;
  logic [CmpW-1:0] lim_ext, eff_lim;
  wave_t           tail;

  assign accept = in_valid_i && in_ready_o;
  assign apply  = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  assign in_ready_o   = (state_q == S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = $signed(rdval_q);
  assign evicted_o    = ev_q;

  always_comb begin
    inject       = '0;
    inject.act   = accept;
    inject.key   = lookup_key_i;
  end

  assign chain[0] = inject;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .RankW (RankW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wave_i (chain[i]),
      .wave_o (chain[i+1]),
      .upd_i  (UpdW'(upd))
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_act
    assign act_vec[i] = chain[i][WaveW-1];
  end

  assign tail    = wave_t'(chain[ENTRIES]);
  assign lim_ext = CmpW'(limit_q);
  assign eff_lim = (lim_ext > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : lim_ext;
  assign lim_nz  = (eff_lim != '0);
  assign full    = (CmpW'(occ_q) >= eff_lim);

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.act) begin
          sum_d   = tail;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    upd.kind = UPD_NONE;
    upd.wr   = mode_q;
    upd.sel  = sum_q.hrank;
    upd.key  = sum_q.key;
    upd.val  = val_q;
    ev_d     = 1'b0;
    occ_d    = occ_q;
    if (apply) begin
      if (sum_q.hit) begin
        if (!mode_q || lim_nz) begin
          upd.kind = UPD_HIT;
        end
      end else if (mode_q && lim_nz) begin
        if (full) begin
          upd.kind = UPD_REPLACE;
          upd.sel  = sum_q.vrank;
          ev_d     = 1'b1;
        end else begin
          upd.kind = UPD_INSERT;
          occ_d    = occ_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LimitRst;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (accept) begin
      mode_q <= mode_i;
      val_q  <= $unsigned(store_value_i);
    end
    if (apply) begin
      hit_q   <= sum_q.hit;
      rdval_q <= (!mode_q && sum_q.hit) ? sum_q.hval : '1;
      ev_q    <= ev_d;
    end
  end

  a_one_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_vec))
    else $error("more than one lookup wave in the cell chain");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(ENTRIES))
    else $error("occupancy beyond capacity");

  a_evict_put_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && ev_d) |-> (mode_q && !sum_q.hit && sum_q.vfound))
    else $error("eviction without a put miss and a victim");

  a_wave_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && tail.act) |=> (state_q == S_APPLY))
    else $error("sequencer missed the end of the lookup wave");

endmodule
